// ===== rtl/core/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the time-to-collision estimator
// Fixed-point widths, special time codes, operation codes and FSM states.
// ----------------------------------------------------------------------------
package tte_pkg;

  // Default path storage depth
  localparam int unsigned PATH_DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned COORD_W = 24;   // Q15.8 position / velocity
  localparam int unsigned REL_W   = 25;   // difference of two coordinates
  localparam int unsigned TTC_W   = 32;   // Q16.16 seconds
  localparam int unsigned SPD_W   = 24;   // Q16.8 speed magnitude
  localparam int unsigned RAD_W   = 16;   // collision radius, Q8.8
  localparam int unsigned PT_W    = 3 * COORD_W;

  // Shared datapath widths
  localparam int unsigned ACC_W    = 52;  // sums of three squares / dot product
  localparam int unsigned ROOT_W   = ACC_W / 2;
  localparam int unsigned MUL_A_W  = 33;
  localparam int unsigned MUL_B_W  = 26;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIFF_W   = 45;  // predicted-to-path distance
  localparam int unsigned D_W      = 17;  // distance once known below radius
  localparam int unsigned Q_FRAC   = 16;  // fraction bits of a time

  // Time codes
  localparam logic [TTC_W-1:0] TTC_INF = '1;
  localparam logic [TTC_W-1:0] TTC_SAT = {{(TTC_W-1){1'b1}}, 1'b0};

  // |p|^2 threshold in Q16 units, |p| > 0.01 m
  localparam logic [ACC_W-1:0] D2_MIN = ACC_W'(7);

  // Default collision radius, 1.0 m
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(256);

  // Configuration register indexes
  localparam logic CFG_USE_PATH = 1'b0;
  localparam logic CFG_RADIUS   = 1'b1;

  typedef enum logic [1:0] {
    OP_OBJECT = 2'd0,
    OP_EGO    = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EGO,
    ST_SEL,
    ST_DOT,
    ST_D2,
    ST_TCHK,
    ST_TDIV_WT,
    ST_SPD_GO,
    ST_SPD_WT,
    ST_RR,
    ST_RR2,
    ST_PREV,
    ST_PWAIT,
    ST_SEG,
    ST_LMAC,
    ST_LSQ_GO,
    ST_LSQ_WT,
    ST_STEP_GO,
    ST_STEP_WT,
    ST_FUT,
    ST_DSQ,
    ST_HIT,
    ST_MIN,
    ST_RMAC,
    ST_RSQ_GO,
    ST_RSQ_WT,
    ST_OUT
  } st_e;

endpackage

// ===== rtl/core/time_to_collision_estimator.sv =====
// ----------------------------------------------------------------------------
// time_to_collision_estimator: per-object time to collision
// Sequencer around one shared multiplier, a root unit and a divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per operation:
//   object, set ego velocity, append path point or clear path. Only an
//   object beat makes a result beat on the output channel
//   (out_valid_o/out_ready_i). Config writes go through cfg_we_i; the user
//   must make them while the block is idle, which the block does not enforce.
//   An object in twist mode runs three sums of products, a 32-step divide
//   when it closes in, and a 26-step root when the frame minimum moves. In
//   path mode a 26-step root of the ego speed is followed, per path segment,
//   by a sum of squares, a 26-step root, a 32-step divide and the hit test,
//   all on the same multiplier and units.
//   in_ready_o is high only between items. A finished result waits in the
//   output register while the next item is taken; the sequencer holds its
//   final step if that register is still full.
//   Reset clears the path, ego velocity, frame minimum (to infinite) and
//   config (use_path off, radius 1.0 m). Path contents need no clearing.
// ----------------------------------------------------------------------------
module time_to_collision_estimator #(
  parameter int unsigned PATH_DEPTH = tte_pkg::PATH_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [tte_pkg::RAD_W-1:0]   cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [tte_pkg::COORD_W-1:0] px_i,
  input  logic [tte_pkg::COORD_W-1:0] py_i,
  input  logic [tte_pkg::COORD_W-1:0] pz_i,
  input  logic [tte_pkg::COORD_W-1:0] vx_i,
  input  logic [tte_pkg::COORD_W-1:0] vy_i,
  input  logic [tte_pkg::COORD_W-1:0] vz_i,
  input  logic                        frame_end_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tte_pkg::TTC_W-1:0]   object_ttc_o,
  output logic                        path_used_o,
  output logic                        frame_done_o,
  output logic [tte_pkg::TTC_W-1:0]   min_ttc_o,
  output logic [tte_pkg::SPD_W-1:0]   min_rel_speed_o
);
  import tte_pkg::*;

  localparam int unsigned ADDR_W = $clog2(PATH_DEPTH);
  localparam int unsigned LEN_W  = $clog2(PATH_DEPTH + 1);

  st_e state_q, state_d;

  // Config and persistent state
  logic                      use_path_q;
  logic [RAD_W-1:0]          radius_q;
  logic signed [COORD_W-1:0] ego_q [3];
  logic [LEN_W-1:0]          len_q;
  logic [TTC_W-1:0]          min_q;
  logic [SPD_W-1:0]          mspd_q;
  logic                      out_valid_q;

  // Per-item working registers
  logic signed [COORD_W-1:0] p_q [3];
  logic signed [COORD_W-1:0] v_q [3];
  logic signed [COORD_W-1:0] prev_q [3];
  logic signed [COORD_W-1:0] cur_q [3];
  logic signed [D_W-1:0]     d_q [3];
  logic                      fe_q, used_q, neg_q, near_q, upd_q;
  logic [1:0]                k_q;
  logic [ADDR_W-1:0]         idx_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]          den_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [ROOT_W-1:0]         spd_q, len_seg_q;
  logic [TTC_W-1:0]          t_q, ttc_q, rr_q;
  logic [SPD_W-1:0]          newspd_q;

  // Handshake
  logic accept, out_load, is_mac, mac_last, path_en, twist_ok, hit, seg_last;
  logic [PT_W-1:0] rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign is_mac     = state_q inside {ST_EGO, ST_DOT, ST_D2, ST_LMAC, ST_DSQ,
                                      ST_RMAC, ST_FUT};
  assign mac_last   = (k_q == 2'd3);

  // Path point store
  tte_ram #(
    .WIDTH (PT_W),
    .DEPTH (PATH_DEPTH)
  ) u_path (
    .clk_i   (clk_i),
    .we_i    (accept && (op_e'(op_i) == OP_APPEND) &&
              (len_q < LEN_W'(PATH_DEPTH))),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i ({pz_i, py_i, px_i}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Component selection for the shared multiplier
  logic [1:0]                ksel, kprev;
  logic signed [REL_W-1:0]   rel_k, seg_k;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  assign ksel  = mac_last ? 2'd0 : k_q;
  assign kprev = (k_q == 2'd0) ? 2'd0 : k_q - 2'd1;
  assign rel_k = {v_q[ksel][COORD_W-1], v_q[ksel]} - {ego_q[ksel][COORD_W-1], ego_q[ksel]};
  assign seg_k = {cur_q[ksel][COORD_W-1], cur_q[ksel]}
               - {prev_q[ksel][COORD_W-1], prev_q[ksel]};

  // Operand mux
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_EGO: begin
        mul_a = MUL_A_W'(ego_q[ksel]);
        mul_b = MUL_B_W'(ego_q[ksel]);
      end
      ST_DOT: begin
        mul_a = MUL_A_W'(rel_k);
        mul_b = MUL_B_W'(p_q[ksel]);
      end
      ST_D2: begin
        mul_a = MUL_A_W'(p_q[ksel]);
        mul_b = MUL_B_W'(p_q[ksel]);
      end
      ST_RMAC: begin
        mul_a = MUL_A_W'(rel_k);
        mul_b = MUL_B_W'(rel_k);
      end
      ST_LMAC: begin
        mul_a = MUL_A_W'(seg_k);
        mul_b = MUL_B_W'(seg_k);
      end
      ST_DSQ: begin
        mul_a = MUL_A_W'(d_q[ksel]);
        mul_b = MUL_B_W'(d_q[ksel]);
      end
      ST_FUT: begin
        mul_a = {1'b0, t_q};
        mul_b = MUL_B_W'(v_q[ksel]);
      end
      ST_RR: begin
        mul_a = MUL_A_W'({1'b0, radius_q});
        mul_b = MUL_B_W'({1'b0, radius_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Predicted position error for the component whose product is in prod_q
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic                     far;

  assign prod_sh  = prod_q >>> Q_FRAC;
  assign diff     = DIFF_W'(cur_q[kprev]) - (DIFF_W'(p_q[kprev]) + prod_sh[DIFF_W-1:0]);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign far      = diff_abs >= DIFF_W'(radius_q);

  // Decisions
  assign path_en  = use_path_q && (len_q > LEN_W'(1)) && (acc_q != '0);
  assign twist_ok = neg_q && ($unsigned(acc_q) >= D2_MIN);
  assign hit      = near_q && ($unsigned(acc_q) < ACC_W'(rr_q));
  assign seg_last = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

  // Shared root and divide units
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]  sq_root;
  logic [TTC_W-1:0]   dv_quo;
  logic [ACC_W-1:0]   dv_num, dv_den;
  logic [TTC_W:0]     t_sum;

  assign sq_start = state_q inside {ST_SPD_GO, ST_LSQ_GO, ST_RSQ_GO};
  assign dv_start = ((state_q == ST_TCHK) && twist_ok) || (state_q == ST_STEP_GO);
  assign dv_num   = (state_q == ST_TCHK) ? $unsigned(acc_q) : ACC_W'(len_seg_q);
  assign dv_den   = (state_q == ST_TCHK) ? den_q : ACC_W'(spd_q);
  assign t_sum    = {1'b0, t_q} + {1'b0, dv_quo};

  tte_sqrt #(
    .RAD_W (ACC_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ($unsigned(acc_q)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  tte_div #(
    .W (ACC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept && (op_e'(op_i) == OP_OBJECT)) state_d = ST_EGO;
      ST_EGO:     if (mac_last) state_d = ST_SEL;
      ST_SEL:     state_d = path_en ? ST_SPD_GO : ST_DOT;
      ST_DOT:     if (mac_last) state_d = ST_D2;
      ST_D2:      if (mac_last) state_d = ST_TCHK;
      ST_TCHK:    state_d = twist_ok ? ST_TDIV_WT : ST_MIN;
      ST_TDIV_WT: if (dv_done) state_d = ST_MIN;
      ST_SPD_GO:  state_d = ST_SPD_WT;
      ST_SPD_WT:  if (sq_done) state_d = ST_RR;
      ST_RR:      state_d = ST_RR2;
      ST_RR2:     state_d = ST_PREV;
      ST_PREV:    state_d = ST_PWAIT;
      ST_PWAIT:   state_d = ST_SEG;
      ST_SEG:     state_d = ST_LMAC;
      ST_LMAC:    if (mac_last) state_d = ST_LSQ_GO;
      ST_LSQ_GO:  state_d = ST_LSQ_WT;
      ST_LSQ_WT:  if (sq_done) state_d = ST_STEP_GO;
      ST_STEP_GO: state_d = ST_STEP_WT;
      ST_STEP_WT: if (dv_done) state_d = ST_FUT;
      ST_FUT:     if (mac_last) state_d = (near_q && !far) ? ST_DSQ : ST_HIT;
      ST_DSQ:     if (mac_last) state_d = ST_HIT;
      ST_HIT:     state_d = (hit || seg_last) ? ST_MIN : ST_PWAIT;
      ST_MIN:     state_d = (ttc_q < min_q) ? ST_RMAC : ST_OUT;
      ST_RMAC:    if (mac_last) state_d = ST_RSQ_GO;
      ST_RSQ_GO:  state_d = ST_RSQ_WT;
      ST_RSQ_WT:  if (sq_done) state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers, config and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      use_path_q  <= 1'b0;
      radius_q    <= RADIUS_RST;
      len_q       <= '0;
      min_q       <= TTC_INF;
      mspd_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ego_q[i] <= '0;
      end
    end else begin
      k_q <= (is_mac && !mac_last) ? k_q + 2'd1 : 2'd0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_USE_PATH: use_path_q <= cfg_data_i[0];
          CFG_RADIUS:   radius_q   <= cfg_data_i;
          default:      use_path_q <= use_path_q;
        endcase
      end

      if (accept) begin
        case (op_e'(op_i))
          OP_EGO: begin
            ego_q[0] <= vx_i;
            ego_q[1] <= vy_i;
            ego_q[2] <= vz_i;
          end
          OP_APPEND: if (len_q < LEN_W'(PATH_DEPTH)) len_q <= len_q + LEN_W'(1);
          OP_CLEAR:  len_q <= '0;
          default:   len_q <= len_q;
        endcase
      end

      // Result beat and frame minimum
      if (out_load) begin
        out_valid_q <= 1'b1;
        min_q  <= fe_q ? TTC_INF : (upd_q ? ttc_q : min_q);
        mspd_q <= fe_q ? '0 : (upd_q ? newspd_q : mspd_q);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (is_mac) begin
      acc_q <= (k_q == 2'd0) ? '0 : acc_q + prod_q[ACC_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          p_q[0] <= px_i;
          p_q[1] <= py_i;
          p_q[2] <= pz_i;
          v_q[0] <= vx_i;
          v_q[1] <= vy_i;
          v_q[2] <= vz_i;
          fe_q   <= frame_end_i;
        end
      end
      ST_SEL: used_q <= path_en;
      ST_D2: begin
        // acc still holds the dot product here
        if (k_q == 2'd0) begin
          neg_q <= acc_q[ACC_W-1];
          den_q <= $unsigned(-acc_q);
        end
      end
      ST_TCHK:    if (!twist_ok) ttc_q <= TTC_INF;
      ST_TDIV_WT: if (dv_done) ttc_q <= dv_quo;
      ST_SPD_GO:  t_q <= '0;
      ST_SPD_WT:  if (sq_done) spd_q <= sq_root;
      ST_RR:      idx_q <= '0;
      ST_RR2:     rr_q <= prod_q[TTC_W-1:0];
      ST_PREV: begin
        prev_q[0] <= rdata[COORD_W-1:0];
        prev_q[1] <= rdata[2*COORD_W-1:COORD_W];
        prev_q[2] <= rdata[3*COORD_W-1:2*COORD_W];
        idx_q     <= ADDR_W'(1);
      end
      ST_SEG: begin
        cur_q[0] <= rdata[COORD_W-1:0];
        cur_q[1] <= rdata[2*COORD_W-1:COORD_W];
        cur_q[2] <= rdata[3*COORD_W-1:2*COORD_W];
      end
      ST_LSQ_WT:  if (sq_done) len_seg_q <= sq_root;
      ST_STEP_WT: begin
        if (dv_done) begin
          t_q <= (t_sum > {1'b0, TTC_SAT}) ? TTC_SAT : t_sum[TTC_W-1:0];
        end
      end
      ST_FUT: begin
        if (k_q == 2'd0) begin
          near_q <= 1'b1;
        end else begin
          d_q[kprev] <= diff[D_W-1:0];
          if (far) near_q <= 1'b0;
        end
      end
      ST_HIT: begin
        if (hit) begin
          ttc_q <= t_q;
        end else if (seg_last) begin
          ttc_q <= TTC_INF;
        end else begin
          prev_q <= cur_q;
          idx_q  <= idx_q + ADDR_W'(1);
        end
      end
      ST_MIN: upd_q <= ttc_q < min_q;
      ST_RSQ_WT: begin
        if (sq_done) begin
          newspd_q <= (sq_root[ROOT_W-1:SPD_W] != '0) ? '1 : sq_root[SPD_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          object_ttc_o    <= ttc_q;
          path_used_o     <= used_q;
          frame_done_o    <= fe_q;
          min_ttc_o       <= upd_q ? ttc_q : min_q;
          min_rel_speed_o <= upd_q ? newspd_q : mspd_q;
        end
      end
      default: begin
        ttc_q <= ttc_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // Walk index stays inside the stored path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == ST_HIT |-> (LEN_W'(idx_q) < len_q))
    else $error("path index beyond path length");
  // Path length never exceeds storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   len_q <= LEN_W'(PATH_DEPTH))
    else $error("path length overflow");
  // Reported minimum never exceeds the object's own time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_load |=> out_valid_o && (min_ttc_o <= object_ttc_o))
    else $error("frame minimum above object time");
  // A frame-end beat restarts the minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_load && fe_q |=> (min_q == TTC_INF) && (mspd_q == '0))
    else $error("frame minimum not cleared at frame end");
`endif

endmodule

// ===== rtl/core/tte_ram.sv =====
// ----------------------------------------------------------------------------
// tte_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/tte_sqrt.sv =====
// ----------------------------------------------------------------------------
// tte_sqrt: iterative floored integer square root
// Two radicand bits per cycle; root_o is valid when done_o rises.
// ----------------------------------------------------------------------------
module tte_sqrt #(
  parameter int unsigned RAD_W = tte_pkg::ACC_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic                 done_o,
  output logic [RAD_W/2-1:0]   root_o
);
  import tte_pkg::*;

  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned REM_W = RT_W + 3;
  localparam int unsigned CNT_W = $clog2(RT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_sh, trial;
  logic [RT_W-1:0]  root_q;
  logic             ge;

  // One digit step
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef ASSERT_OFF
  // A new start is never issued while a root is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("sqrt restarted while busy");
  // done is set as the work ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $fell(busy_q) |-> done_q)
    else $error("sqrt finished without done");
  // The remainder never exceeds twice the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy_q |-> rem_q <= {1'b0, root_q, 1'b0})
    else $error("sqrt remainder out of range");
`endif

endmodule

// ===== rtl/core/tte_div.sv =====
// ----------------------------------------------------------------------------
// tte_div: iterative Q16.16 quotient with saturation
// Gives floor(num * 2^16 / den), saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tte_div #(
  parameter int unsigned W = tte_pkg::ACC_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [W-1:0]              num_i,
  input  logic [W-1:0]              den_i,
  output logic                      done_o,
  output logic [tte_pkg::TTC_W-1:0] quo_o
);
  import tte_pkg::*;

  localparam int unsigned CNT_W = $clog2(TTC_W);

  logic             busy_q, done_q, sat_start;
  logic [CNT_W-1:0] cnt_q;
  logic [W:0]       r_q, r_sh;
  logic [W-1:0]     den_q;
  logic [TTC_W-1:0] sh_q, q_q;
  logic             ge;

  // Integer part of the quotient beyond 16 bits
  assign sat_start = {{Q_FRAC{1'b0}}, num_i[W-1:Q_FRAC]} >= den_i;

  // One restoring step
  assign r_sh = {r_q[W-1:0], sh_q[TTC_W-1]};
  assign ge   = r_sh >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !sat_start;
      done_q <= sat_start;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TTC_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder, shifted dividend bits and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= {{(Q_FRAC+1){1'b0}}, num_i[W-1:Q_FRAC]};
      sh_q  <= {num_i[Q_FRAC-1:0], {Q_FRAC{1'b0}}};
      den_q <= den_i;
      q_q   <= sat_start ? TTC_SAT : '0;
    end else if (busy_q) begin
      r_q  <= ge ? r_sh - {1'b0, den_q} : r_sh;
      sh_q <= {sh_q[TTC_W-2:0], 1'b0};
      q_q  <= {q_q[TTC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (q_q == TTC_INF) ? TTC_SAT : q_q;

`ifndef ASSERT_OFF
  // Divisor must be nonzero at start
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> den_i != '0)
    else $error("divide by zero");
  // Remainder stays below the divisor while working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy_q && !start_i |-> r_q < {1'b0, den_q})
    else $error("div remainder out of range");
  // A result is never shown as infinite
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> quo_o != TTC_INF)
    else $error("div produced infinite code");
`endif

endmodule
